// ----- rtl/lpcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcp_pkg
// shared types and constants of the lidar point projection pipeline
// ----------------------------------------------------------------------------
package lpcp_pkg;

	localparam int COEF_W  = 21;   // packed Q2.18 / Q3.18 / Q5.16 register entries
	localparam int PT_W    = 24;   // Q8.16 point coordinate
	localparam int CAM_W   = 30;   // Q16 camera-frame coordinate
	localparam int NORM_W  = 21;   // Q18 normalised coordinate, [-4, 4)
	localparam int PIX_W   = 16;   // Q12.4 pixel
	localparam int DEPTH_W = 23;   // Q7.16 depth, unsigned
	localparam int IDX_W   = 17;   // emitted point index
	localparam int FRAC    = 18;   // fraction bits dropped after each product

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ROT0  = 3'd0,
		REG_ROT1  = 3'd1,
		REG_ROT2  = 3'd2,
		REG_TRANS = 3'd3,
		REG_FOCAL = 3'd4,
		REG_RAD   = 3'd5,
		REG_TAN   = 3'd6,
		REG_SIZE  = 3'd7
	} cfg_reg_t;

	// sideband that travels with every word through the pipeline
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

// ----- rtl/lpcp_xform.sv -----
// ----------------------------------------------------------------------------
// lpcp_xform
// rigid transform of a lidar point into the camera frame, two stages
// ----------------------------------------------------------------------------
module lpcp_xform
	import lpcp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [62:0]              rot0,
	input  logic [62:0]              rot1,
	input  logic [62:0]              rot2,
	input  logic [62:0]              trans,
	input  logic signed [PT_W-1:0]   px,
	input  logic signed [PT_W-1:0]   py,
	input  logic signed [PT_W-1:0]   pz,
	input  tag_t                     tag_in,
	output logic signed [CAM_W-1:0]  xc,
	output logic signed [CAM_W-1:0]  yc,
	output logic signed [CAM_W-1:0]  zc,
	output tag_t                     tag_out
);

	localparam int PROD_W = COEF_W + PT_W;
	localparam int ACC_W  = PROD_W + 3;

	logic signed [COEF_W-1:0] rm [3][3];
	logic signed [COEF_W-1:0] tv [3];
	logic signed [PT_W-1:0]   pv [3];
	logic signed [ACC_W-1:0]  acc [3];

	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [COEF_W-1:0] t_s1 [3];
	tag_t                     tag_s1;
	logic signed [CAM_W-1:0]  cam_s2 [3];
	tag_t                     tag_s2;

	always_comb begin
		pv[0] = px;
		pv[1] = py;
		pv[2] = pz;
		for (int c = 0; c < 3; c++) begin
			rm[0][c] = rot0[COEF_W*c +: COEF_W];
			rm[1][c] = rot1[COEF_W*c +: COEF_W];
			rm[2][c] = rot2[COEF_W*c +: COEF_W];
			tv[c]    = trans[COEF_W*c +: COEF_W];
		end
	end

	// stage 1: nine products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s1 <= '0;
		else if (adv) tag_s1 <= tag_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				t_s1[r] <= tv[r];
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= rm[r][c] * pv[c];
			end
		end
	end

	// stage 2: row sums plus translation, floor to Q16
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1]) + ACC_W'(prod_s1[r][2])
				+ (ACC_W'(t_s1[r]) <<< FRAC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s2 <= '0;
		else if (adv) tag_s2 <= tag_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) cam_s2[r] <= CAM_W'(acc[r] >>> FRAC);
		end
	end

	assign xc      = cam_s2[0];
	assign yc      = cam_s2[1];
	assign zc      = cam_s2[2];
	assign tag_out = tag_s2;

endmodule

// ----- rtl/lpcp_div.sv -----
// ----------------------------------------------------------------------------
// lpcp_div
// pipelined restoring divider, x/z and y/z to saturated Q18, one bit a stage
// ----------------------------------------------------------------------------
module lpcp_div
	import lpcp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic signed [CAM_W-1:0]   xc,
	input  logic signed [CAM_W-1:0]   yc,
	input  logic signed [CAM_W-1:0]   zc,
	input  tag_t                      tag_in,
	output logic signed [NORM_W-1:0]  xn,
	output logic signed [NORM_W-1:0]  yn,
	output logic [DEPTH_W-1:0]        depth,
	output tag_t                      tag_out
);

	localparam int QB    = NORM_W;          // quotient bits per division
	localparam int DEN_W = CAM_W - 1;
	localparam int REM_W = CAM_W + FRAC;
	localparam int DIF_W = REM_W + 2;
	localparam logic [NORM_W-1:0] POS_MAX = {1'b0, {(NORM_W-1){1'b1}}};
	localparam logic [NORM_W-1:0] NEG_MIN = {1'b1, {(NORM_W-1){1'b0}}};

	logic [CAM_W-1:0]   ax, ay;
	logic [CAM_W+2:0]   den8;
	logic               zpos;

	logic [REM_W-1:0]   remx_s [0:QB];
	logic [REM_W-1:0]   remy_s [0:QB];
	logic [QB-1:0]      qx_s   [0:QB];
	logic [QB-1:0]      qy_s   [0:QB];
	logic [DEN_W-1:0]   den_s  [0:QB];
	logic [3:0]         flg_s  [0:QB];   // neg x, ovf x, neg y, ovf y
	logic [DEPTH_W-1:0] dep_s  [0:QB];
	tag_t               tag_s  [0:QB];

	logic signed [NORM_W-1:0] xn_sf, yn_sf;
	logic [DEPTH_W-1:0]       dep_sf;
	tag_t                     tag_sf;

	always_comb begin
		ax   = xc[CAM_W-1] ? CAM_W'(-xc) : CAM_W'(xc);
		ay   = yc[CAM_W-1] ? CAM_W'(-yc) : CAM_W'(yc);
		zpos = !zc[CAM_W-1] && (zc != '0);
		den8 = {4'b0, zc[DEN_W-1:0]} << 3;
	end

	// entry stage: magnitudes, signs, overflow of the quotient range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s[0] <= '0;
		else if (adv) tag_s[0] <= '{vld: tag_in.vld && zpos, last: tag_in.last, idx: tag_in.idx};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			remx_s[0] <= {ax, {FRAC{1'b0}}};
			remy_s[0] <= {ay, {FRAC{1'b0}}};
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			den_s[0]  <= zc[DEN_W-1:0];
			flg_s[0]  <= {xc[CAM_W-1], ({3'b0, ax} >= den8), yc[CAM_W-1], ({3'b0, ay} >= den8)};
			dep_s[0]  <= (zc > CAM_W'({DEPTH_W{1'b1}})) ? {DEPTH_W{1'b1}} : zc[DEPTH_W-1:0];
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int B = QB - 1 - j;
		logic [DIF_W-1:0] dsh, dx, dy;

		always_comb begin
			dsh = DIF_W'(den_s[j]) << B;
			dx  = DIF_W'(remx_s[j]) - dsh;
			dy  = DIF_W'(remy_s[j]) - dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_s[j+1] <= '0;
			else if (adv) tag_s[j+1] <= tag_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				remx_s[j+1] <= dx[DIF_W-1] ? remx_s[j] : dx[REM_W-1:0];
				remy_s[j+1] <= dy[DIF_W-1] ? remy_s[j] : dy[REM_W-1:0];
				qx_s[j+1]   <= qx_s[j] | (QB'(!dx[DIF_W-1]) << B);
				qy_s[j+1]   <= qy_s[j] | (QB'(!dy[DIF_W-1]) << B);
				den_s[j+1]  <= den_s[j];
				flg_s[j+1]  <= flg_s[j];
				dep_s[j+1]  <= dep_s[j];
			end
		end
	end

	// sign and saturation to [-4, 4)
	function automatic logic [NORM_W-1:0] fix_q(input logic [QB-1:0] mag, input logic neg,
		input logic ovf);
		logic big;
		big = mag[QB-1] && (mag[QB-2:0] != '0);
		if (neg) fix_q = (ovf || big) ? NEG_MIN : NORM_W'(-mag);
		else     fix_q = (ovf || mag[QB-1]) ? POS_MAX : mag;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_sf <= '0;
		else if (adv) tag_sf <= tag_s[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xn_sf  <= fix_q(qx_s[QB], flg_s[QB][3], flg_s[QB][2]);
			yn_sf  <= fix_q(qy_s[QB], flg_s[QB][1], flg_s[QB][0]);
			dep_sf <= dep_s[QB];
		end
	end

	assign xn      = xn_sf;
	assign yn      = yn_sf;
	assign depth   = dep_sf;
	assign tag_out = tag_sf;

endmodule

// ----- rtl/lpcp_dist.sv -----
// ----------------------------------------------------------------------------
// lpcp_dist
// lens distortion, pixel mapping and image bounds test, ten stages
// ----------------------------------------------------------------------------
module lpcp_dist
	import lpcp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [62:0]               radial,
	input  logic [41:0]               tangential,
	input  logic [63:0]               focal,
	input  logic [31:0]               img_size,
	input  logic signed [NORM_W-1:0]  xn,
	input  logic signed [NORM_W-1:0]  yn,
	input  logic [DEPTH_W-1:0]        depth_in,
	input  tag_t                      tag_in,
	output logic [PIX_W-1:0]          row,
	output logic [PIX_W-1:0]          col,
	output logic [DEPTH_W-1:0]        depth,
	output tag_t                      tag_out
);

	localparam int NS  = 10;
	localparam int SQ_W = 2*NORM_W;   // raw x*x
	localparam int XX_W = 25;         // xx, yy, xy, r2
	localparam int TA_W = 27;         // r2 + 2xx
	localparam int R4R_W = 50;
	localparam int R4_W = R4R_W - FRAC;
	localparam int R6R_W = R4_W + XX_W;
	localparam int R6_W = R6R_W - FRAC;
	localparam int P_W  = COEF_W + TA_W;
	localparam int RS_W = 58;
	localparam int RAD_W = RS_W - FRAC;
	localparam int XR_W = NORM_W + RAD_W;
	localparam int XD_W = XR_W + 2;
	localparam int XQ_W = XD_W - FRAC;
	localparam int XF_W = XQ_W + PIX_W + 1;
	localparam int PX_W = XF_W - FRAC + 1;

	logic signed [COEF_W-1:0] k1, k2, k3, p1, p2;
	logic signed [PIX_W:0]    fx, fy;
	logic signed [PX_W-1:0]   cx, cy, hlim, wlim;

	tag_t               tag_s [1:NS];
	logic [DEPTH_W-1:0] dep_s [1:NS];

	// stage payload
	logic signed [NORM_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic signed [NORM_W-1:0] x_s6, y_s6;
	logic signed [SQ_W-1:0]   xx_s1, yy_s1, xy_s1;
	logic signed [XX_W-1:0]   xy_s2, r2_s2, r2_s3;
	logic signed [TA_W-1:0]   tax_s2, tay_s2;
	logic signed [R4R_W-1:0]  r4r_s3;
	logic signed [P_W-1:0]    k1r2_s3, pxy1_s3, pxa_s3, pya_s3, pxy2_s3;
	logic signed [P_W-1:0]    k1r2_s4, pxy1_s4, pxa_s4, pya_s4, pxy2_s4;
	logic signed [P_W-1:0]    k1r2_s5, pxy1_s5, pxa_s5, pya_s5, pxy2_s5;
	logic signed [P_W-1:0]    pxy1_s6, pxa_s6, pya_s6, pxy2_s6;
	logic signed [P_W-1:0]    pxy1_s7, pxa_s7, pya_s7, pxy2_s7;
	logic signed [R6R_W-1:0]  r6r_s4;
	logic signed [R4R_W-1:0]  k2r4_s4, k2r4_s5;
	logic signed [RS_W-1:0]   k3r6_s5;
	logic signed [RAD_W-1:0]  rad_s6;
	logic signed [XR_W-1:0]   xr_s7, yr_s7;
	logic signed [XQ_W-1:0]   xd_s8, yd_s8;
	logic signed [XF_W-1:0]   xf_s9, yf_s9;
	logic [PIX_W-1:0]         row_s10, col_s10;

	logic signed [XX_W-1:0]   xx_c, yy_c, xy_c, r2_c;
	logic signed [R4_W-1:0]   r4_c;
	logic signed [R6_W-1:0]   r6_c;
	logic signed [RS_W-1:0]   rsum_c;
	logic signed [XD_W-1:0]   xds_c, yds_c;
	logic signed [PX_W-1:0]   rowf_c, colf_c;
	logic                     inside_c;

	always_comb begin
		k1   = radial[0 +: COEF_W];
		k2   = radial[COEF_W +: COEF_W];
		k3   = radial[2*COEF_W +: COEF_W];
		p1   = tangential[0 +: COEF_W];
		p2   = tangential[COEF_W +: COEF_W];
		fx   = $signed({1'b0, focal[15:0]});
		fy   = $signed({1'b0, focal[31:16]});
		cx   = PX_W'({1'b0, focal[47:32]});
		cy   = PX_W'({1'b0, focal[63:48]});
		hlim = PX_W'({1'b0, img_size[15:0], 4'b0});
		wlim = PX_W'({1'b0, img_size[31:16], 4'b0});

		xx_c   = XX_W'(xx_s1 >>> FRAC);
		yy_c   = XX_W'(yy_s1 >>> FRAC);
		xy_c   = XX_W'(xy_s1 >>> FRAC);
		r2_c   = xx_c + yy_c;
		r4_c   = R4_W'(r4r_s3 >>> FRAC);
		r6_c   = R6_W'(r6r_s4 >>> FRAC);
		rsum_c = (RS_W'(1) <<< 36) + RS_W'(k1r2_s5) + RS_W'(k2r4_s5) + k3r6_s5;
		xds_c  = XD_W'(xr_s7) + (XD_W'(pxy1_s7) <<< 1) + XD_W'(pxa_s7);
		yds_c  = XD_W'(yr_s7) + XD_W'(pya_s7) + (XD_W'(pxy2_s7) <<< 1);
		rowf_c = PX_W'(xf_s9 >>> FRAC) + cx;
		colf_c = PX_W'(yf_s9 >>> FRAC) + cy;
		inside_c = (colf_c > 0) && (colf_c < wlim) && (rowf_c > 0) && (rowf_c < hlim);
	end

	// sideband and depth ride along; the last stage drops points outside the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) tag_s[i] <= '0;
		end else if (adv) begin
			tag_s[1] <= tag_in;
			for (int i = 2; i < NS; i++) tag_s[i] <= tag_s[i-1];
			tag_s[NS] <= '{vld: tag_s[NS-1].vld && inside_c, last: tag_s[NS-1].last,
				idx: tag_s[NS-1].idx};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dep_s[1] <= depth_in;
			for (int i = 2; i <= NS; i++) dep_s[i] <= dep_s[i-1];

			// s1: squares and cross product
			x_s1  <= xn;
			y_s1  <= yn;
			xx_s1 <= xn * xn;
			yy_s1 <= yn * yn;
			xy_s1 <= xn * yn;

			// s2: r2 and tangential sums
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			xy_s2  <= xy_c;
			r2_s2  <= r2_c;
			tax_s2 <= TA_W'(r2_c) + (TA_W'(xx_c) <<< 1);
			tay_s2 <= TA_W'(r2_c) + (TA_W'(yy_c) <<< 1);

			// s3: r4, k1 r2, tangential products
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			r2_s3   <= r2_s2;
			r4r_s3  <= R4R_W'(r2_s2 * r2_s2);
			k1r2_s3 <= P_W'(k1 * r2_s2);
			pxy1_s3 <= P_W'(p1 * xy_s2);
			pxa_s3  <= p2 * tax_s2;
			pya_s3  <= p1 * tay_s2;
			pxy2_s3 <= P_W'(p2 * xy_s2);

			// s4: r6, k2 r4
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			r6r_s4  <= r4_c * r2_s3;
			k2r4_s4 <= R4R_W'(k2 * r4_c);
			k1r2_s4 <= k1r2_s3;
			pxy1_s4 <= pxy1_s3;
			pxa_s4  <= pxa_s3;
			pya_s4  <= pya_s3;
			pxy2_s4 <= pxy2_s3;

			// s5: k3 r6
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			k3r6_s5 <= RS_W'(k3 * r6_c);
			k2r4_s5 <= k2r4_s4;
			k1r2_s5 <= k1r2_s4;
			pxy1_s5 <= pxy1_s4;
			pxa_s5  <= pxa_s4;
			pya_s5  <= pya_s4;
			pxy2_s5 <= pxy2_s4;

			// s6: radial factor
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			rad_s6  <= RAD_W'(rsum_c >>> FRAC);
			pxy1_s6 <= pxy1_s5;
			pxa_s6  <= pxa_s5;
			pya_s6  <= pya_s5;
			pxy2_s6 <= pxy2_s5;

			// s7: radial scaling
			xr_s7   <= x_s6 * rad_s6;
			yr_s7   <= y_s6 * rad_s6;
			pxy1_s7 <= pxy1_s6;
			pxa_s7  <= pxa_s6;
			pya_s7  <= pya_s6;
			pxy2_s7 <= pxy2_s6;

			// s8: distorted coordinates
			xd_s8 <= XQ_W'(xds_c >>> FRAC);
			yd_s8 <= XQ_W'(yds_c >>> FRAC);

			// s9: focal scaling
			xf_s9 <= XF_W'(xd_s8 * fx);
			yf_s9 <= XF_W'(yd_s8 * fy);

			// s10: centre offset and saturation
			row_s10 <= (rowf_c > PX_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : rowf_c[PIX_W-1:0];
			col_s10 <= (colf_c > PX_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : colf_c[PIX_W-1:0];
		end
	end

	assign row     = row_s10;
	assign col     = col_s10;
	assign depth   = dep_s[NS];
	assign tag_out = tag_s[NS];

endmodule

// ----- rtl/lidar_point_camera_projection_unit.sv -----
// throughput: one point per cycle while m_tready does not stall; the divider and the
// distortion multiplier chain are fully pipelined
// a stall on m_tready freezes every stage together, nothing is dropped or repeated
// reset: arst_n clears the configuration registers, the frame counter and every stage valid bit
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_unit
// lidar point to camera pixel projection with lens distortion, pipelined
// ----------------------------------------------------------------------------
module lidar_point_camera_projection_unit
	import lpcp_pkg::*;
#(
	parameter int MAX_POINTS = 131072
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,

	// point input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,    // point_x [23:0], point_y [47:24], point_z [71:48]
	input  logic        s_tlast,    // last_in_frame

	// pixel output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,    // row_coord [15:0], col_coord [31:16], depth [54:32],
	                                // point_index [71:55]
	output logic        m_tlast     // frame_end
);

	localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// configuration registers, masked to their widths
	logic [62:0] rot0_q, rot1_q, rot2_q, trans_q, rad_q;
	logic [63:0] focal_q;
	logic [41:0] tan_q;
	logic [31:0] size_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0]   cnt_inc;
	logic [EXT_W-1:0] cnt_ext;
	logic             adv;
	logic             in_fire;
	tag_t             tag_in;

	logic signed [CAM_W-1:0]  xc, yc, zc;
	tag_t                     tag_xf;
	logic signed [NORM_W-1:0] xn, yn;
	logic [DEPTH_W-1:0]       dep_dv;
	tag_t                     tag_dv;
	logic [PIX_W-1:0]         row, col;
	logic [DEPTH_W-1:0]       dep_out;
	tag_t                     tag_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot0_q  <= '0;
			rot1_q  <= '0;
			rot2_q  <= '0;
			trans_q <= '0;
			focal_q <= '0;
			rad_q   <= '0;
			tan_q   <= '0;
			size_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROT0:  rot0_q  <= cfg_data[62:0];
				REG_ROT1:  rot1_q  <= cfg_data[62:0];
				REG_ROT2:  rot2_q  <= cfg_data[62:0];
				REG_TRANS: trans_q <= cfg_data[62:0];
				REG_FOCAL: focal_q <= cfg_data;
				REG_RAD:   rad_q   <= cfg_data[62:0];
				REG_TAN:   tan_q   <= cfg_data[41:0];
				REG_SIZE:  size_q  <= cfg_data[31:0];
				default:   ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign in_fire  = s_tvalid && adv;

	// per-frame sequence counter, every accepted point takes one index
	assign cnt_inc = {1'b0, cnt_q} + 1'b1;
	assign cnt_ext = EXT_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (in_fire) begin
			if (s_tlast || (cnt_inc >= (CNT_W+1)'(MAX_POINTS))) cnt_q <= '0;
			else cnt_q <= cnt_inc[CNT_W-1:0];
		end
	end

	assign tag_in = '{vld: s_tvalid, last: s_tlast, idx: cnt_ext[IDX_W-1:0]};

	// camera frame transform
	lpcp_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rot0    (rot0_q),
		.rot1    (rot1_q),
		.rot2    (rot2_q),
		.trans   (trans_q),
		.px      ($signed(s_tdata[23:0])),
		.py      ($signed(s_tdata[47:24])),
		.pz      ($signed(s_tdata[71:48])),
		.tag_in  (tag_in),
		.xc      (xc),
		.yc      (yc),
		.zc      (zc),
		.tag_out (tag_xf)
	);

	// perspective divide, drops points with non-positive depth
	lpcp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.xc      (xc),
		.yc      (yc),
		.zc      (zc),
		.tag_in  (tag_xf),
		.xn      (xn),
		.yn      (yn),
		.depth   (dep_dv),
		.tag_out (tag_dv)
	);

	// distortion, pixel mapping and bounds; its last stage is the output register
	lpcp_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.radial     (rad_q),
		.tangential (tan_q),
		.focal      (focal_q),
		.img_size   (size_q),
		.xn         (xn),
		.yn         (yn),
		.depth_in   (dep_dv),
		.tag_in     (tag_dv),
		.row        (row),
		.col        (col),
		.depth      (dep_out),
		.tag_out    (tag_out)
	);

	assign m_tvalid = tag_out.vld;
	assign m_tdata  = {tag_out.idx, dep_out, col, row};
	assign m_tlast  = tag_out.last;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// lidar point projection unit: directed and random points under several camera
// setups, each pixel word checked against a fixed-point projection model
// ----------------------------------------------------------------------------
module testbench;
	import lpcp_pkg::*;

	typedef struct {
		logic [15:0] row;
		logic [15:0] col;
		logic [22:0] depth;
		logic [16:0] idx;
		logic        last;
	} pixel_t;

	localparam longint ONE_ROT = 64'd1 << 18;   // 1.0 in Q2.18 / Q3.18
	localparam int     LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;      // point_x, point_y, point_z
	logic        s_tlast = 1'b0;    // last_in_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // row_coord, col_coord, depth, point_index
	logic        m_tlast;           // frame_end

	logic [63:0] cam_regs [8];      // mirror of the register file
	int unsigned frame_pos = 0;     // mirror of the point counter
	pixel_t      pending_pixels [$];
	int          errors = 0;
	int          cycles = 0;
	int          hold_left = 0;     // long back-pressure request, in cycles
	bit          rx_steady = 1'b0;  // receiver never idles while set
	bit          tx_steady = 1'b0;  // sender never idles while set

	lidar_point_camera_projection_unit dut (.*);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic longint coef(input logic [63:0] r, input int k);
		logic [20:0] f;
		f = r[21*k +: 21];
		return longint'($signed(f));
	endfunction

	function automatic longint norm_q18(input longint num, input longint den);
		longint q;
		q = (num <<< 18) / den;    // truncates toward zero
		if (q >= (64'sd1 <<< 20)) q = (64'sd1 <<< 20) - 1;
		if (q < -(64'sd1 <<< 20)) q = -(64'sd1 <<< 20);
		return q;
	endfunction

	function automatic longint clamp_pix(input longint v);
		if (v < 0) return 0;
		if (v > 65535) return 65535;
		return v;
	endfunction

	// returns 1 when the point lands inside the image
	function automatic bit project_point(input logic [23:0] xi, yi, zi, output pixel_t p);
		longint px, py, pz, cam [3], x, y, xx, yy, xy, r2, r4, r6, rad, xd, yd;
		longint k1, k2, k3, p1, p2, row, col, hlim, wlim;
		px = longint'($signed(xi));
		py = longint'($signed(yi));
		pz = longint'($signed(zi));
		for (int i = 0; i < 3; i++)
			cam[i] = (coef(cam_regs[i], 0) * px + coef(cam_regs[i], 1) * py +
				coef(cam_regs[i], 2) * pz + (coef(cam_regs[REG_TRANS], i) <<< 18)) >>> 18;
		p = '{default: '0};
		if (cam[2] <= 0) return 1'b0;
		x  = norm_q18(cam[0], cam[2]);
		y  = norm_q18(cam[1], cam[2]);
		xx = (x * x) >>> 18;
		yy = (y * y) >>> 18;
		xy = (x * y) >>> 18;
		r2 = xx + yy;
		r4 = (r2 * r2) >>> 18;
		r6 = (r4 * r2) >>> 18;
		k1 = coef(cam_regs[REG_RAD], 0);
		k2 = coef(cam_regs[REG_RAD], 1);
		k3 = coef(cam_regs[REG_RAD], 2);
		p1 = coef(cam_regs[REG_TAN], 0);
		p2 = coef(cam_regs[REG_TAN], 1);
		rad = ((64'sd1 <<< 36) + k1 * r2 + k2 * r4 + k3 * r6) >>> 18;
		xd = (x * rad + 2 * p1 * xy + p2 * (r2 + 2 * xx)) >>> 18;
		yd = (y * rad + p1 * (r2 + 2 * yy) + 2 * p2 * xy) >>> 18;
		row = ((xd * longint'(cam_regs[REG_FOCAL][15:0])) >>> 18) +
			longint'(cam_regs[REG_FOCAL][47:32]);
		col = ((yd * longint'(cam_regs[REG_FOCAL][31:16])) >>> 18) +
			longint'(cam_regs[REG_FOCAL][63:48]);
		// first coordinate against the height, second against the width
		hlim = longint'(cam_regs[REG_SIZE][15:0]) * 16;
		wlim = longint'(cam_regs[REG_SIZE][31:16]) * 16;
		if (!(0 < col && col < wlim && 0 < row && row < hlim)) return 1'b0;
		p.row   = 16'(clamp_pix(row));
		p.col   = 16'(clamp_pix(col));
		p.depth = (cam[2] > 8388607) ? 23'h7FFFFF : 23'(cam[2]);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- sender
	task automatic send_point(input logic [23:0] x, y, z, input bit last);
		pixel_t p;
		if (!tx_steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (project_point(x, y, z, p)) begin
			p.idx  = 17'(frame_pos);
			p.last = last;
			pending_pixels.insert(pending_pixels.size(), p);
		end
		frame_pos = last ? 0 : ((frame_pos + 1 >= 131072) ? 0 : frame_pos + 1);
	endtask

	// waits out the pipeline so the registers can change
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// writes all eight registers, one per cycle
	task automatic load_camera(input logic [63:0] regs [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= regs[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cam_regs[REG_ROT0]  = regs[REG_ROT0] & 64'h7FFF_FFFF_FFFF_FFFF;
		cam_regs[REG_ROT1]  = regs[REG_ROT1] & 64'h7FFF_FFFF_FFFF_FFFF;
		cam_regs[REG_ROT2]  = regs[REG_ROT2] & 64'h7FFF_FFFF_FFFF_FFFF;
		cam_regs[REG_TRANS] = regs[REG_TRANS] & 64'h7FFF_FFFF_FFFF_FFFF;
		cam_regs[REG_FOCAL] = regs[REG_FOCAL];
		cam_regs[REG_RAD]   = regs[REG_RAD] & 64'h7FFF_FFFF_FFFF_FFFF;
		cam_regs[REG_TAN]   = regs[REG_TAN] & 64'h3FF_FFFF_FFFF;
		cam_regs[REG_SIZE]  = regs[REG_SIZE] & 64'hFFFF_FFFF;
	endtask

	function automatic logic [63:0] pack3(input longint a, b, c);
		return {1'b0, 21'(c), 21'(b), 21'(a)};
	endfunction

	// a plain camera: identity rotation, 500 px focal length, 640 x 640 image
	function automatic void plain_camera(output logic [63:0] regs [8]);
		regs[REG_ROT0]  = pack3(ONE_ROT, 0, 0);
		regs[REG_ROT1]  = pack3(0, ONE_ROT, 0);
		regs[REG_ROT2]  = pack3(0, 0, ONE_ROT);
		regs[REG_TRANS] = '0;
		regs[REG_FOCAL] = {16'd5120, 16'd5120, 16'd8000, 16'd8000};
		regs[REG_RAD]   = '0;
		regs[REG_TAN]   = '0;
		regs[REG_SIZE]  = {16'd640, 16'd640};
	endfunction

	// a point in front of the camera, mostly within the field of view
	task automatic send_visible(input bit last);
		int z, s;
		z = $urandom_range(1 << 22, 1 << 16);
		s = z * 3 / 4;
		send_point(24'($urandom_range(2 * s) - s), 24'($urandom_range(2 * s) - s),
			24'(z), last);
	endtask

	// ---------------------------------------------------------------- receiver
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= rx_steady || ($urandom_range(99) >= 28);
		end
	end

	// checks every pixel word against the oldest prediction
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel word with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = pending_pixels.pop_front();
				if (m_tdata[15:0] !== e.row) begin
					$error("row_coord expected %0d actual %0d", e.row, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== e.col) begin
					$error("col_coord expected %0d actual %0d", e.col, m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[54:32] !== e.depth) begin
					$error("depth expected %0d actual %0d", e.depth, m_tdata[54:32]);
					errors++;
				end
				if (m_tdata[71:55] !== e.idx) begin
					$error("point_index expected %0d actual %0d", e.idx, m_tdata[71:55]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("frame_end expected %0d actual %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// plain camera: centre, depth edges, field extremes and frame marks
	task automatic test_plain_camera();
		logic [63:0] regs [8];
		plain_camera(regs);
		load_camera(regs);
		send_point(24'd0, 24'd0, 24'd655360, 1'b0);             // optical axis at 10 m
		send_point(24'd65536, 24'hFF0000, 24'd131072, 1'b0);   // off axis
		send_point(24'd0, 24'd0, 24'd0, 1'b0);                 // zero depth
		send_point(24'd0, 24'd0, 24'hFFFFFF, 1'b0);            // negative depth
		send_point(24'd0, 24'd0, 24'd1, 1'b0);                 // smallest depth
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);  // largest values
		send_point(24'h800000, 24'h800000, 24'h7FFFFF, 1'b1);  // smallest values
		send_point(24'd100, 24'd100, 24'h7FFFFF, 1'b0);        // counter restarted
		send_point(24'h7FFFFF, 24'd0, 24'd65536, 1'b1);        // far outside, clamped ratio
		drain();
	endtask

	// strong distortion, tangential terms and translation
	task automatic test_distortion();
		logic [63:0] regs [8];
		plain_camera(regs);
		regs[REG_TRANS] = pack3(-32768, 16384, 65536);
		regs[REG_RAD]   = pack3(-(1 << 17), 1 << 16, -(1 << 15));
		regs[REG_TAN]   = pack3(1 << 12, -(1 << 12), 0);
		load_camera(regs);
		for (int i = 0; i < 5; i++) send_visible(i == 4);
		drain();
		// coefficient extremes
		regs[REG_RAD] = pack3(20'hFFFFF, -(1 << 20), 20'hFFFFF);
		regs[REG_TAN] = pack3(-(1 << 20), 20'hFFFFF, 0);
		load_camera(regs);
		for (int i = 0; i < 4; i++) send_visible(1'b0);
		drain();
	endtask

	// zero focal length puts every pixel at the centre; a maximal centre reaches the largest pixel code
	task automatic test_focal_edges();
		logic [63:0] regs [8];
		plain_camera(regs);
		regs[REG_FOCAL] = {16'd5120, 16'd5120, 16'd0, 16'd0};
		load_camera(regs);
		send_visible(1'b0);
		send_visible(1'b0);
		drain();
		regs[REG_FOCAL] = {16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
		regs[REG_SIZE]  = 64'hFFFF_FFFF;
		load_camera(regs);
		send_visible(1'b0);
		send_visible(1'b1);
		drain();
	endtask

	// random points under a run of random and extreme (all ones, all zeros) cameras
	task automatic test_random_points();
		logic [63:0] regs [8];
		for (int phase = 0; phase < 7; phase++) begin
			plain_camera(regs);
			case (phase)
				1: regs = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
				2: regs = '{default: 64'h0};
				default: begin
					for (int i = 0; i < 3; i++)
						regs[i] = regs[i] + pack3($urandom_range(8000) - 4000,
							$urandom_range(8000) - 4000, $urandom_range(8000) - 4000);
					regs[REG_TRANS] = pack3($urandom_range(1 << 17) - (1 << 16),
						$urandom_range(1 << 17) - (1 << 16), $urandom_range(1 << 17) - (1 << 16));
					regs[REG_FOCAL] = {16'($urandom_range(16000, 3000)),
						16'($urandom_range(16000, 3000)),
						16'($urandom_range(20000, 1000)), 16'($urandom_range(20000, 1000))};
					regs[REG_RAD] = pack3($urandom_range(1 << 18) - (1 << 17),
						$urandom_range(1 << 17) - (1 << 16), $urandom_range(1 << 16) - (1 << 15));
					regs[REG_TAN] = pack3($urandom_range(1 << 14) - (1 << 13),
						$urandom_range(1 << 14) - (1 << 13), 0);
					regs[REG_SIZE] = {16'($urandom_range(1300, 400)), 16'($urandom_range(1300, 400))};
				end
			endcase
			load_camera(regs);
			rx_steady = (phase == 3);
			tx_steady = (phase == 3);
			for (int n = 0; n < 260; n++) begin
				// a long receiver hold-off while points keep coming
				if (phase == 4 && n == 20) hold_left = 300;
				if ($urandom_range(99) < 70)
					send_visible($urandom_range(99) < 3);
				else
					send_point(24'($urandom), 24'($urandom), 24'($urandom),
						$urandom_range(99) < 5);
			end
			rx_steady = 1'b0;
			tx_steady = 1'b0;
			drain();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_camera();
		test_distortion();
		test_focal_edges();
		test_random_points();
		if (errors == 0 && pending_pixels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- lidar_point_camera_projection_unit.f -----
rtl/lpcp_pkg.sv
rtl/lpcp_xform.sv
rtl/lpcp_div.sv
rtl/lpcp_dist.sv
rtl/lidar_point_camera_projection_unit.sv
tb/testbench.sv
